FILE: design/lfu_cache_table_defines.svh
// assertion macros shared by the lfu cache table rtl
`ifndef LFU_CACHE_TABLE_DEFINES_SVH
`define LFU_CACHE_TABLE_DEFINES_SVH

// same-cycle implication, checked on every rising clock edge out of reset
`define LFU_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked on every rising clock edge out of reset
`define LFU_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: design/lfu_pkg.sv
// types and constants of the lfu cache table
`default_nettype none

package lfu_pkg;

   localparam int KEY_W   = 32;
   localparam int VAL_W   = 32;
   localparam int COUNT_W = 32;
   localparam int STAMP_W = 48;
   localparam int CAP_REG_W = 5;

   localparam logic [CAP_REG_W-1:0] CAP_RESET = 5'd16;
   localparam logic [COUNT_W-1:0]   COUNT_MAX = 32'hFFFF_FFFF;
   localparam logic [COUNT_W-1:0]   COUNT_ONE = 32'd1;
   localparam logic [STAMP_W-1:0]   STAMP_ONE = 48'd1;

   localparam logic REQ_GET = 1'b0;
   localparam logic REQ_PUT = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_WRITE
   } state_type;

   typedef struct packed {
      logic [KEY_W-1:0]   key;
      logic [VAL_W-1:0]   value;
      logic [COUNT_W-1:0] use_count;
      logic [STAMP_W-1:0] last_use;
   } entry_type;

endpackage

`default_nettype wire

FILE: design/lfu_cache_table.sv
// lfu cache table: key/value cache with least-frequently-used replacement
//
// request channel (req_): one word is a get or a put with a key and a value,
//   taken when req_valid is high and req_stall is low
// response channel (rsp_): exactly one word per request: hit, read value on a
//   get hit, and the evicted key when a put pushed out another entry
// csr channel: write of capacity_in_use, taken when csr_valid and csr_ready;
//   csr_ready is high only while the sequencer is idle
// each request scans the occupied entries one per cycle through the entry
//   memory read port and a single compare unit (key match plus lowest count,
//   oldest stamp victim search), then writes back at most one entry
// a request passes through the scan and write-back states before its word
//   reaches the output register and rsp_valid; a new request is taken only
//   after the previous one is through; req_stall stays high until the
//   write-back cycle has handed its word to the output register
// the output register lets the next request be accepted and scanned while the
//   previous response is stalled; write-back waits only if the register is
//   still full
// reset (synchronous, active high) empties the table via the fill count,
//   sets capacity to 16 and clears the stamp clock; no clearing pass is needed
`default_nettype none

`include "lfu_cache_table_defines.svh"

module lfu_cache_table
   import lfu_pkg::*;
#(
   parameter int CAPACITY = 16
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   // request channel
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire logic                 req_type,
   input  wire logic [KEY_W-1:0]     req_key,
   input  wire logic [VAL_W-1:0]     req_value,
   // response channel
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output logic                      rsp_hit,
   output logic [VAL_W-1:0]          rsp_read_value,
   output logic                      rsp_evicted,
   output logic [KEY_W-1:0]          rsp_evicted_key,
   // csr channel
   input  wire logic                 csr_valid,
   output logic                      csr_ready,
   input  wire logic [CAP_REG_W-1:0] csr_capacity_in_use
);

   localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int OCC_W = $clog2(CAPACITY + 1);
   localparam int CAP_W = (OCC_W > CAP_REG_W) ? OCC_W : CAP_REG_W;

   // sequencer and architectural state
   state_type              state_ff, state_in;
   logic [CAP_REG_W-1:0]   capacity_ff, capacity_in;
   logic [OCC_W-1:0]       occ_ff, occ_in;          // valid entries are slots 0..occ-1
   logic [STAMP_W-1:0]     use_clock_ff, use_clock_in;

   // captured request
   logic                   req_type_ff, req_type_in;
   logic [KEY_W-1:0]       req_key_ff, req_key_in;
   logic [VAL_W-1:0]       req_value_ff, req_value_in;

   // scan pipeline
   logic [OCC_W-1:0]       issue_ff, issue_in;
   logic                   rd_vld_ff, rd_vld_in;
   logic [IDX_W-1:0]       rd_idx_ff, rd_idx_in;
   logic [IDX_W-1:0]       rd_addr;
   entry_type              rd_data_ff;

   // match tracker
   logic                   found_ff, found_in;
   logic [IDX_W-1:0]       match_idx_ff, match_idx_in;
   logic [VAL_W-1:0]       match_val_ff, match_val_in;
   logic [COUNT_W-1:0]     match_cnt_ff, match_cnt_in;

   // victim tracker
   logic                   have_vic_ff, have_vic_in;
   logic [IDX_W-1:0]       vic_idx_ff, vic_idx_in;
   logic [COUNT_W-1:0]     vic_cnt_ff, vic_cnt_in;
   logic [STAMP_W-1:0]     vic_stamp_ff, vic_stamp_in;
   logic [KEY_W-1:0]       vic_key_ff, vic_key_in;

   // output register
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_hit_ff, rsp_hit_in;
   logic [VAL_W-1:0]       rsp_read_value_ff, rsp_read_value_in;
   logic                   rsp_evicted_ff, rsp_evicted_in;
   logic [KEY_W-1:0]       rsp_evicted_key_ff, rsp_evicted_key_in;

   // entry memory write port
   logic                   wr_en;
   logic [IDX_W-1:0]       wr_addr;
   entry_type              wr_data;

   entry_type              entry_mem [CAPACITY];

   // compare unit and helpers
   logic                   key_eq;
   logic                   vic_better;
   logic [CAP_W-1:0]       cap_eff;
   logic [CAP_W-1:0]       occ_ext;
   logic                   req_accept;
   logic                   out_free;
   logic [COUNT_W-1:0]     match_cnt_inc;

   assign req_stall       = (state_ff != ST_IDLE);
   assign csr_ready       = (state_ff == ST_IDLE);
   assign req_accept      = req_valid && !req_stall;
   assign out_free        = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_hit         = rsp_hit_ff;
   assign rsp_read_value  = rsp_read_value_ff;
   assign rsp_evicted     = rsp_evicted_ff;
   assign rsp_evicted_key = rsp_evicted_key_ff;

   // capacity register above the table size saturates at the table size
   assign cap_eff = (CAP_W'(capacity_ff) > CAP_W'(CAPACITY)) ?
                    CAP_W'(CAPACITY) : CAP_W'(capacity_ff);
   assign occ_ext = CAP_W'(occ_ff);

   assign rd_addr = issue_ff[IDX_W-1:0];

   // one compare unit shared by every scan step
   assign key_eq     = (rd_data_ff.key == req_key_ff);
   assign vic_better = !have_vic_ff ||
                       (rd_data_ff.use_count < vic_cnt_ff) ||
                       ((rd_data_ff.use_count == vic_cnt_ff) &&
                        (rd_data_ff.last_use < vic_stamp_ff));

   // saturating use count
   assign match_cnt_inc = (match_cnt_ff == COUNT_MAX) ? match_cnt_ff :
                          match_cnt_ff + COUNT_ONE;

   always_comb begin
      state_in           = state_ff;
      capacity_in        = capacity_ff;
      occ_in             = occ_ff;
      use_clock_in       = use_clock_ff;
      req_type_in        = req_type_ff;
      req_key_in         = req_key_ff;
      req_value_in       = req_value_ff;
      issue_in           = issue_ff;
      rd_vld_in          = 1'b0;
      rd_idx_in          = rd_addr;
      found_in           = found_ff;
      match_idx_in       = match_idx_ff;
      match_val_in       = match_val_ff;
      match_cnt_in       = match_cnt_ff;
      have_vic_in        = have_vic_ff;
      vic_idx_in         = vic_idx_ff;
      vic_cnt_in         = vic_cnt_ff;
      vic_stamp_in       = vic_stamp_ff;
      vic_key_in         = vic_key_ff;
      rsp_valid_in       = rsp_valid_ff && rsp_stall;
      rsp_hit_in         = rsp_hit_ff;
      rsp_read_value_in  = rsp_read_value_ff;
      rsp_evicted_in     = rsp_evicted_ff;
      rsp_evicted_key_in = rsp_evicted_key_ff;
      wr_en              = 1'b0;
      wr_addr            = match_idx_ff;
      wr_data            = '{key: req_key_ff, value: req_value_ff,
                             use_count: COUNT_ONE, last_use: use_clock_ff};

      if (csr_valid && csr_ready) begin
         capacity_in = csr_capacity_in_use;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               req_type_in  = req_type;
               req_key_in   = req_key;
               req_value_in = req_value;
               issue_in     = '0;
               found_in     = 1'b0;
               have_vic_in  = 1'b0;
               state_in     = ST_SCAN;
            end
         end

         ST_SCAN: begin
            // issue one read per cycle over the occupied slots
            if (issue_ff < occ_ff) begin
               rd_vld_in = 1'b1;
               issue_in  = issue_ff + OCC_W'(1);
            end
            // evaluate the entry read in the previous cycle
            if (rd_vld_ff) begin
               if (!found_ff && key_eq) begin
                  found_in     = 1'b1;
                  match_idx_in = rd_idx_ff;
                  match_val_in = rd_data_ff.value;
                  match_cnt_in = rd_data_ff.use_count;
               end
               if (vic_better) begin
                  have_vic_in  = 1'b1;
                  vic_idx_in   = rd_idx_ff;
                  vic_cnt_in   = rd_data_ff.use_count;
                  vic_stamp_in = rd_data_ff.last_use;
                  vic_key_in   = rd_data_ff.key;
               end
            end
            if ((issue_ff == occ_ff) && !rd_vld_ff) begin
               state_in = ST_WRITE;
            end
         end

         ST_WRITE: begin
            // write-back waits for room in the output register
            if (out_free) begin
               rsp_valid_in       = 1'b1;
               rsp_hit_in         = 1'b0;
               rsp_read_value_in  = '0;
               rsp_evicted_in     = 1'b0;
               rsp_evicted_key_in = '0;
               state_in           = ST_IDLE;

               if (req_type_ff == REQ_GET) begin
                  if (found_ff) begin
                     rsp_hit_in        = 1'b1;
                     rsp_read_value_in = match_val_ff;
                     wr_en             = 1'b1;
                     wr_addr           = match_idx_ff;
                     wr_data.value     = match_val_ff;
                     wr_data.use_count = match_cnt_inc;
                     use_clock_in      = use_clock_ff + STAMP_ONE;
                  end
               end else if (cap_eff != '0) begin
                  if (found_ff) begin
                     rsp_hit_in        = 1'b1;
                     wr_en             = 1'b1;
                     wr_addr           = match_idx_ff;
                     wr_data.use_count = match_cnt_inc;
                     use_clock_in      = use_clock_ff + STAMP_ONE;
                  end else if (occ_ext < cap_eff) begin
                     // fill the next free slot
                     wr_en        = 1'b1;
                     wr_addr      = occ_ff[IDX_W-1:0];
                     occ_in       = occ_ff + OCC_W'(1);
                     use_clock_in = use_clock_ff + STAMP_ONE;
                  end else if (have_vic_ff) begin
                     // evict the victim and refill its slot
                     rsp_evicted_in     = 1'b1;
                     rsp_evicted_key_in = vic_key_ff;
                     wr_en              = 1'b1;
                     wr_addr            = vic_idx_ff;
                     use_clock_in       = use_clock_ff + STAMP_ONE;
                  end
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         capacity_ff  <= CAP_RESET;
         occ_ff       <= '0;
         use_clock_ff <= '0;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         issue_ff     <= '0;
         found_ff     <= 1'b0;
         have_vic_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         capacity_ff  <= capacity_in;
         occ_ff       <= occ_in;
         use_clock_ff <= use_clock_in;
         rd_vld_ff    <= rd_vld_in;
         rsp_valid_ff <= rsp_valid_in;
         issue_ff     <= issue_in;
         found_ff     <= found_in;
         have_vic_ff  <= have_vic_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      req_type_ff        <= req_type_in;
      req_key_ff         <= req_key_in;
      req_value_ff       <= req_value_in;
      rd_idx_ff          <= rd_idx_in;
      match_idx_ff       <= match_idx_in;
      match_val_ff       <= match_val_in;
      match_cnt_ff       <= match_cnt_in;
      vic_idx_ff         <= vic_idx_in;
      vic_cnt_ff         <= vic_cnt_in;
      vic_stamp_ff       <= vic_stamp_in;
      vic_key_ff         <= vic_key_in;
      rsp_hit_ff         <= rsp_hit_in;
      rsp_read_value_ff  <= rsp_read_value_in;
      rsp_evicted_ff     <= rsp_evicted_in;
      rsp_evicted_key_ff <= rsp_evicted_key_in;
   end

   // entry memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= entry_mem[rd_addr];
   end

   `LFU_ASSERT_NOW(a_occ_bound, 1'b1, occ_ff <= OCC_W'(CAPACITY), "occupancy above table size")
   `LFU_ASSERT_NOW(a_hit_no_evict, rsp_valid_ff, !(rsp_hit_ff && rsp_evicted_ff), "hit with eviction")
   `LFU_ASSERT_NOW(a_evict_occupied, rsp_valid_ff && rsp_evicted_ff, occ_ff != '0, "eviction from empty table")
   `LFU_ASSERT_NEXT(a_accept_scan, req_accept, state_ff == ST_SCAN, "accepted word did not start a scan")
   `LFU_ASSERT_NEXT(a_clock_hold, !wr_en, $stable(use_clock_ff), "stamp clock moved without a write")

endmodule

`default_nettype wire
